// ===== src/sfrnd_pkg.sv =====
// Package: constants and status codes for the sync frame receiver nibble decoder.
`timescale 1ns / 1ps

package sfrnd_pkg;

  localparam int unsigned FRAME_LEN     = 7;
  localparam int unsigned PATH_SLOTS    = 7;
  localparam int unsigned KEY_SLOTS     = 3;
  localparam int unsigned STORE_DEPTH   = FRAME_LEN - 1;

  localparam int unsigned MAX_PATH_KEPT_DEF = 7;
  localparam int unsigned MAX_KEYS_KEPT_DEF = 3;

  localparam logic [3:0] NIBBLE_MAX  = 4'd12;

  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_START_SYNC = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_END_SYNC   = 1'b1;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_PATH_VAL = 3'd1;
  localparam logic [2:0] ST_PATH_GAP = 3'd2;
  localparam logic [2:0] ST_KEY_VAL  = 3'd3;
  localparam logic [2:0] ST_KEY_GAP  = 3'd4;

endpackage

// ===== src/sync_frame_receiver_nibble_decoder.sv =====
// Top level: sync byte deframer with path and key nibble decoder.
`timescale 1ns / 1ps

// Accepts one received byte per cycle and emits one result per good frame.
// A frame is the start sync byte, five payload bytes and the end sync byte;
// a frame whose first or last byte does not match the sync registers is
// dropped, and a failing last byte equal to the start sync opens a new frame.
// The payload unpacks into seven path nibbles and three key nibbles, which are
// checked for values above 12 and for nonzero entries after a zero; on error
// only decode_status is nonzero. Every byte passes an input register and the
// frame logic lands the result in an output register, so a result goes out
// from there after the last byte has left the input register. Throughput is
// one byte per cycle; the input stalls only while a result waits in the output
// register and the next byte must go through the frame logic.
module sync_frame_receiver_nibble_decoder #(
  parameter int unsigned MAX_PATH_KEPT = sfrnd_pkg::MAX_PATH_KEPT_DEF,
  parameter int unsigned MAX_KEYS_KEPT = sfrnd_pkg::MAX_KEYS_KEPT_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,

  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [sfrnd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                     cfg_data,

  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [7:0]                     in_rx_byte,

  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [2:0]                     out_decode_status,
  output logic [27:0]                    out_path_nibbles,
  output logic [2:0]                     out_path_count,
  output logic [11:0]                    out_key_nibbles,
  output logic [1:0]                     out_key_count
);

  logic [7:0]  start_sync_r;
  logic [7:0]  end_sync_r;

  logic        s1_vld_r;
  logic [7:0]  s1_byte_r;
  logic        adv;

  logic [2:0]  pos_r;
  logic [2:0]  pos_nxt;
  logic [7:0]  frame_r [0:sfrnd_pkg::STORE_DEPTH-1];
  logic        wr_first;
  logic        wr_body;
  logic        emit;

  logic [3:0]  path_v [0:sfrnd_pkg::PATH_SLOTS-1];
  logic [3:0]  key_v  [0:sfrnd_pkg::KEY_SLOTS-1];
  logic [2:0]  status_nxt;
  logic [27:0] path_nib_nxt;
  logic [2:0]  path_cnt_nxt;
  logic [11:0] key_nib_nxt;
  logic [1:0]  key_cnt_nxt;

  logic        path_big;
  logic        path_gap;
  logic        key_big;
  logic        key_gap;
  logic        zseen_p;
  logic        zseen_k;
  logic        stop_p;
  logic        stop_k;

  logic        out_valid_r;
  logic [2:0]  status_r;
  logic [27:0] path_nib_r;
  logic [2:0]  path_cnt_r;
  logic [11:0] key_nib_r;
  logic [1:0]  key_cnt_r;

  assign cfg_ready = 1'b1;
  assign adv       = s1_vld_r && (!out_valid_r || out_ready);
  assign in_ready  = !s1_vld_r || adv;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_sync_r <= 8'd0;
      end_sync_r   <= 8'd0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        sfrnd_pkg::CFG_START_SYNC: start_sync_r <= cfg_data;
        sfrnd_pkg::CFG_END_SYNC:   end_sync_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_vld_r <= 1'b1;
    end else if (adv) begin
      s1_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte_r <= in_rx_byte;
    end
  end

  // frame position control
  always_comb begin
    pos_nxt  = pos_r;
    wr_first = 1'b0;
    wr_body  = 1'b0;
    emit     = 1'b0;
    if (pos_r == 3'd0 || pos_r >= 3'(sfrnd_pkg::FRAME_LEN)) begin
      pos_nxt = 3'd0;
      if (s1_byte_r == start_sync_r) begin
        wr_first = 1'b1;
        pos_nxt  = 3'd1;
      end
    end else if (pos_r == 3'(sfrnd_pkg::FRAME_LEN - 1)) begin
      pos_nxt = 3'd0;
      if (frame_r[0] == start_sync_r && s1_byte_r == end_sync_r) begin
        emit = 1'b1;
      end else if (s1_byte_r == start_sync_r) begin
        wr_first = 1'b1;
        pos_nxt  = 3'd1;
      end
    end else begin
      wr_body = 1'b1;
      pos_nxt = pos_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= 3'd0;
    end else if (adv) begin
      pos_r <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && wr_first) begin
      frame_r[0] <= s1_byte_r;
    end else if (adv && wr_body) begin
      frame_r[pos_r] <= s1_byte_r;
    end
  end

  // nibble unpack, check and pack
  always_comb begin
    path_v[0] = frame_r[1][7:4];
    path_v[1] = frame_r[1][3:0];
    path_v[2] = frame_r[2][7:4];
    path_v[3] = frame_r[2][3:0];
    path_v[4] = frame_r[3][7:4];
    path_v[5] = frame_r[3][3:0];
    path_v[6] = frame_r[4][7:4];
    key_v[0]  = frame_r[4][3:0];
    key_v[1]  = frame_r[5][7:4];
    key_v[2]  = frame_r[5][3:0];

    path_big = 1'b0;
    path_gap = 1'b0;
    zseen_p  = 1'b0;
    for (int i = 0; i < sfrnd_pkg::PATH_SLOTS; i++) begin
      if (path_v[i] > sfrnd_pkg::NIBBLE_MAX) path_big = 1'b1;
      if (path_v[i] == 4'd0) zseen_p = 1'b1;
      else if (zseen_p) path_gap = 1'b1;
    end

    key_big = 1'b0;
    key_gap = 1'b0;
    zseen_k = 1'b0;
    for (int i = 0; i < sfrnd_pkg::KEY_SLOTS; i++) begin
      if (key_v[i] > sfrnd_pkg::NIBBLE_MAX) key_big = 1'b1;
      if (key_v[i] == 4'd0) zseen_k = 1'b1;
      else if (zseen_k) key_gap = 1'b1;
    end

    if (path_big)      status_nxt = sfrnd_pkg::ST_PATH_VAL;
    else if (path_gap) status_nxt = sfrnd_pkg::ST_PATH_GAP;
    else if (key_big)  status_nxt = sfrnd_pkg::ST_KEY_VAL;
    else if (key_gap)  status_nxt = sfrnd_pkg::ST_KEY_GAP;
    else               status_nxt = sfrnd_pkg::ST_OK;

    path_nib_nxt = 28'd0;
    path_cnt_nxt = 3'd0;
    stop_p       = 1'b0;
    for (int i = 0; i < sfrnd_pkg::PATH_SLOTS; i++) begin
      if (path_v[i] == 4'd0) stop_p = 1'b1;
      if (!stop_p && path_cnt_nxt < 3'(MAX_PATH_KEPT)) begin
        path_nib_nxt[27 - 4*i -: 4] = path_v[i];
        path_cnt_nxt = path_cnt_nxt + 3'd1;
      end
    end

    key_nib_nxt = 12'd0;
    key_cnt_nxt = 2'd0;
    stop_k      = 1'b0;
    for (int i = 0; i < sfrnd_pkg::KEY_SLOTS; i++) begin
      if (key_v[i] == 4'd0) stop_k = 1'b1;
      if (!stop_k && key_cnt_nxt < 2'(MAX_KEYS_KEPT)) begin
        key_nib_nxt[11 - 4*i -: 4] = key_v[i];
        key_cnt_nxt = key_cnt_nxt + 2'd1;
      end
    end

    if (status_nxt != sfrnd_pkg::ST_OK) begin
      path_nib_nxt = 28'd0;
      path_cnt_nxt = 3'd0;
      key_nib_nxt  = 12'd0;
      key_cnt_nxt  = 2'd0;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv && emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && emit) begin
      status_r   <= status_nxt;
      path_nib_r <= path_nib_nxt;
      path_cnt_r <= path_cnt_nxt;
      key_nib_r  <= key_nib_nxt;
      key_cnt_r  <= key_cnt_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_decode_status = status_r;
  assign out_path_nibbles  = path_nib_r;
  assign out_path_count    = path_cnt_r;
  assign out_key_nibbles   = key_nib_r;
  assign out_key_count     = key_cnt_r;

endmodule

// ===== verif/tb_sync_frame_receiver_nibble_decoder.sv =====
// Testbench for the sync frame receiver nibble decoder, checked against a predictor.
`timescale 1ns / 1ps

module tb_sync_frame_receiver_nibble_decoder;

  localparam int unsigned PATH_CAP = sfrnd_pkg::MAX_PATH_KEPT_DEF;
  localparam int unsigned KEY_CAP  = sfrnd_pkg::MAX_KEYS_KEPT_DEF;
  localparam int DIR_LEN = 37;
  localparam int PHASE_BYTES = 160;

  typedef struct packed {
    logic [2:0]  status;
    logic [27:0] path;
    logic [2:0]  path_cnt;
    logic [11:0] keys;
    logic [1:0]  key_cnt;
  } decode_t;

  typedef enum logic {ROW_CFG, ROW_RX} row_kind_t;

  typedef struct packed {
    row_kind_t                        kind;
    logic [sfrnd_pkg::CFG_IDX_W-1:0]  idx;
    logic [7:0]                       data;
    logic                             typed;
    decode_t                          want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [sfrnd_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [7:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [7:0] in_rx_byte = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [2:0] out_decode_status;
  logic [27:0] out_path_nibbles;
  logic [2:0] out_path_count;
  logic [11:0] out_key_nibbles;
  logic [1:0] out_key_count;

  // predictor state
  logic [7:0] sync_open;
  logic [7:0] sync_close;
  int unsigned held;
  logic [7:0] frame_buf [sfrnd_pkg::FRAME_LEN];

  decode_t awaited_decodes [$];
  dir_row_t dir_rows [DIR_LEN];
  int fail_count = 0;
  bit steady = 1'b0;

  sync_frame_receiver_nibble_decoder #(
    .MAX_PATH_KEPT(PATH_CAP),
    .MAX_KEYS_KEPT(KEY_CAP)
  ) u_top (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_rx_byte(in_rx_byte),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_decode_status(out_decode_status),
    .out_path_nibbles(out_path_nibbles),
    .out_path_count(out_path_count),
    .out_key_nibbles(out_key_nibbles),
    .out_key_count(out_key_count)
  );

  always #4 clk = ~clk;

  initial begin
    #2ms;
    $display("simulation failed");
    $finish;
  end

  always @(negedge clk) begin
    out_ready <= steady || ($urandom_range(99) >= 14);
  end

  // nibble k of the payload, k = 0 is the high nibble of the first payload byte
  function automatic logic [3:0] nib_at(input logic [39:0] pl, input int k);
    return pl[39-4*k -: 4];
  endfunction

  function automatic logic [2:0] group_status(input logic [39:0] pl, input int first,
                                              input int n, input logic [2:0] range_code,
                                              input logic [2:0] gap_code);
    bit zero_seen;
    int i;
    zero_seen = 1'b0;
    for (i = 0; i < n; i++) begin
      if (nib_at(pl, first + i) > sfrnd_pkg::NIBBLE_MAX) return range_code;
    end
    for (i = 0; i < n; i++) begin
      if (nib_at(pl, first + i) == 4'h0) zero_seen = 1'b1;
      else if (zero_seen) return gap_code;
    end
    return sfrnd_pkg::ST_OK;
  endfunction

  function automatic logic [27:0] group_pack(input logic [39:0] pl, input int first,
                                             input int n, input int unsigned cap,
                                             output int unsigned cnt);
    logic [27:0] acc;
    logic [3:0] v;
    bit stopped;
    int i;
    acc = '0;
    cnt = 0;
    stopped = 1'b0;
    for (i = 0; i < n; i++) begin
      v = nib_at(pl, first + i);
      if (v == 4'h0) stopped = 1'b1;
      if (!stopped && cnt < cap) begin
        acc = {acc[23:0], v};
        cnt++;
      end else begin
        acc = {acc[23:0], 4'h0};
      end
    end
    return acc;
  endfunction

  function automatic decode_t decode_payload(input logic [39:0] pl);
    decode_t r;
    int unsigned pc;
    int unsigned kc;
    logic [27:0] kp;
    r = '0;
    r.status = group_status(pl, 0, sfrnd_pkg::PATH_SLOTS, sfrnd_pkg::ST_PATH_VAL,
                            sfrnd_pkg::ST_PATH_GAP);
    if (r.status == sfrnd_pkg::ST_OK)
      r.status = group_status(pl, sfrnd_pkg::PATH_SLOTS, sfrnd_pkg::KEY_SLOTS,
                              sfrnd_pkg::ST_KEY_VAL, sfrnd_pkg::ST_KEY_GAP);
    if (r.status != sfrnd_pkg::ST_OK) return r;
    r.path = group_pack(pl, 0, sfrnd_pkg::PATH_SLOTS, PATH_CAP, pc);
    kp = group_pack(pl, sfrnd_pkg::PATH_SLOTS, sfrnd_pkg::KEY_SLOTS, KEY_CAP, kc);
    r.path_cnt = 3'(pc);
    r.keys = kp[11:0];
    r.key_cnt = 2'(kc);
    return r;
  endfunction

  // advances the frame state by one byte; returns 1 when a good frame completes
  function automatic bit predict_rx(input logic [7:0] b, output decode_t res);
    res = '0;
    if (held == 0) begin
      if (b == sync_open) begin
        frame_buf[0] = b;
        held = 1;
      end
      return 1'b0;
    end
    frame_buf[held] = b;
    held++;
    if (held < sfrnd_pkg::FRAME_LEN) return 1'b0;
    held = 0;
    if (frame_buf[0] == sync_open && frame_buf[sfrnd_pkg::FRAME_LEN-1] == sync_close) begin
      res = decode_payload({frame_buf[1], frame_buf[2], frame_buf[3], frame_buf[4],
                            frame_buf[5]});
      return 1'b1;
    end
    if (b == sync_open) begin
      frame_buf[0] = b;
      held = 1;
    end
    return 1'b0;
  endfunction

  function automatic dir_row_t row_rx(input logic [7:0] b);
    return '{kind: ROW_RX, idx: '0, data: b, typed: 1'b0, want: '0};
  endfunction

  function automatic dir_row_t row_chk(input logic [7:0] b, input decode_t w);
    return '{kind: ROW_RX, idx: '0, data: b, typed: 1'b1, want: w};
  endfunction

  function automatic dir_row_t row_cfg(input logic [sfrnd_pkg::CFG_IDX_W-1:0] i,
                                       input logic [7:0] d);
    return '{kind: ROW_CFG, idx: i, data: d, typed: 1'b0, want: '0};
  endfunction

  task automatic check_field(input string what, input logic [27:0] want, input logic [27:0] got);
    if (want !== got) begin
      $display("%0t %s mismatch: expected %0h, actual %0h", $time, what, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    decode_t want;
    if (rst_n && out_valid && out_ready) begin
      if (awaited_decodes.size() == 0) begin
        $display("%0t unexpected result: expected none, actual status %0h", $time,
                 out_decode_status);
        fail_count++;
      end else begin
        want = awaited_decodes.pop_front();
        check_field("decode_status", 28'(want.status), 28'(out_decode_status));
        check_field("path_nibbles", want.path, out_path_nibbles);
        check_field("path_count", 28'(want.path_cnt), 28'(out_path_count));
        check_field("key_nibbles", 28'(want.keys), 28'(out_key_nibbles));
        check_field("key_count", 28'(want.key_cnt), 28'(out_key_count));
      end
    end
  end

  // called at a falling edge, returns at a falling edge
  task automatic send_rx(input logic [7:0] b, input logic typed, input decode_t w);
    decode_t res;
    bit got;
    while (!steady && $urandom_range(99) < 14) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    got = predict_rx(b, res);
    if (typed) awaited_decodes.push_back(w);
    else if (got) awaited_decodes.push_back(res);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [sfrnd_pkg::CFG_IDX_W-1:0] i, input logic [7:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= i;
    cfg_data <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (i)
      sfrnd_pkg::CFG_START_SYNC: sync_open = d;
      sfrnd_pkg::CFG_END_SYNC:   sync_close = d;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // frames that end without a result may still be in the pipeline
  task automatic drain_idle();
    in_valid <= 1'b0;
    while (awaited_decodes.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    logic [7:0] opens [5];
    logic [7:0] closes [5];
    logic [39:0] payload;
    int plen;
    int klen;
    int k;
    int pick;
    int sent;
    int ph;
    bit paused;

    sync_open = '0;
    sync_close = '0;
    held = 0;
    opens = '{8'h00, 8'hFF, 8'h5A, 8'($urandom), 8'($urandom)};
    closes = '{8'hFF, 8'h00, 8'h5A, 8'($urandom), 8'($urandom)};

    dir_rows = '{
      row_rx(8'h00), row_rx(8'h00), row_rx(8'h00), row_rx(8'h00), row_rx(8'h00),
      row_rx(8'h00),
      row_chk(8'h00, '{sfrnd_pkg::ST_OK, 28'h0, 3'd0, 12'h0, 2'd0}),
      row_cfg(sfrnd_pkg::CFG_START_SYNC, 8'hFF), row_cfg(sfrnd_pkg::CFG_END_SYNC, 8'h7E),
      row_rx(8'hFF), row_rx(8'h12), row_rx(8'h34), row_rx(8'h56), row_rx(8'h7C),
      row_rx(8'h9A),
      row_chk(8'h7E, '{sfrnd_pkg::ST_OK, 28'h1234567, 3'd7, 12'hC9A, 2'd3}),
      // bad end byte equal to start sync reopens a frame
      row_rx(8'hFF), row_rx(8'h11), row_rx(8'h11), row_rx(8'h11), row_rx(8'h11),
      row_rx(8'h11), row_rx(8'hFF),
      row_rx(8'hD0), row_rx(8'h00), row_rx(8'h00), row_rx(8'h00), row_rx(8'h00),
      row_chk(8'h7E, '{sfrnd_pkg::ST_PATH_VAL, 28'h0, 3'd0, 12'h0, 2'd0}),
      // start sync changed while a frame is open: frame dropped
      row_rx(8'hFF), row_rx(8'h12), row_rx(8'h34),
      row_cfg(sfrnd_pkg::CFG_START_SYNC, 8'h00),
      row_rx(8'h56), row_rx(8'h78), row_rx(8'h9A), row_rx(8'h7E)
    };

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (k = 0; k < DIR_LEN; k++) begin
      if (dir_rows[k].kind == ROW_CFG) begin
        drain_idle();
        write_reg(dir_rows[k].idx, dir_rows[k].data);
      end else begin
        send_rx(dir_rows[k].data, dir_rows[k].typed, dir_rows[k].want);
      end
    end

    for (ph = 0; ph < 5; ph++) begin
      drain_idle();
      write_reg(sfrnd_pkg::CFG_START_SYNC, opens[ph]);
      write_reg(sfrnd_pkg::CFG_END_SYNC, closes[ph]);
      steady = (ph == 1);
      sent = 0;
      paused = 1'b0;
      while (sent < PHASE_BYTES) begin
        if (ph == 2 && !paused && sent >= PHASE_BYTES / 2) begin
          in_valid <= 1'b0;
          while (awaited_decodes.size() != 0) @(posedge clk);
          @(negedge clk);
          paused = 1'b1;
        end
        pick = $urandom_range(99);
        if (pick < 70) begin
          plen = $urandom_range(sfrnd_pkg::PATH_SLOTS);
          klen = $urandom_range(sfrnd_pkg::KEY_SLOTS);
          payload = '0;
          for (k = 0; k < sfrnd_pkg::PATH_SLOTS; k++)
            if (k < plen) payload[39-4*k -: 4] = 4'($urandom_range(12, 1));
          for (k = 0; k < sfrnd_pkg::KEY_SLOTS; k++)
            if (k < klen) payload[11-4*k -: 4] = 4'($urandom_range(12, 1));
          if ($urandom_range(1) == 1) begin
            k = $urandom_range(9);
            payload[39-4*k -: 4] = 4'($urandom_range(15, 0));
          end
          if ($urandom_range(9) == 0) payload = {$urandom, 8'($urandom)};
          send_rx(sync_open, 1'b0, '0);
          for (k = 0; k < 5; k++) send_rx(payload[39-8*k -: 8], 1'b0, '0);
          send_rx(sync_close, 1'b0, '0);
          sent += sfrnd_pkg::FRAME_LEN;
        end else if (pick < 82) begin
          send_rx(sync_open, 1'b0, '0);
          for (k = 0; k < 5; k++) send_rx(8'($urandom), 1'b0, '0);
          send_rx(($urandom_range(1) == 1) ? sync_open : 8'($urandom), 1'b0, '0);
          sent += sfrnd_pkg::FRAME_LEN;
        end else begin
          repeat ($urandom_range(4, 1)) send_rx(8'($urandom), 1'b0, '0);
        end
      end
      steady = 1'b0;
    end

    drain_idle();
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
